[hdl/iouta_pkg.sv]
// iouta_pkg: shared constants, codes and record types of the iou track association block
// no dependencies; used by every module under hdl
`timescale 1ns / 1ps
`default_nettype none
package iouta_pkg;

   localparam int TRACK_SLOTS = 32;
   localparam int COORD_BITS  = 12;
   localparam int BOX_BITS    = 12;
   localparam int CLASS_BITS  = 8;
   localparam int ID_BITS     = 16;
   localparam int MISS_BITS   = 8;
   localparam int THR_BITS    = 9;
   localparam int TOTAL_BITS  = 32;
   localparam int LIVE_OUT_W  = 6;
   localparam int STATUS_W    = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int IDX_W      = $clog2(TRACK_SLOTS);
   localparam int SCORE_LAT  = 3;
   localparam int CNT_W      = $clog2(TRACK_SLOTS + SCORE_LAT + 1);
   localparam int LIVE_W     = $clog2(TRACK_SLOTS + 1);
   localparam int AREA_W     = 2 * COORD_BITS;
   localparam int UNI_W      = 2 * COORD_BITS + 1;
   localparam int PROD_W     = AREA_W + UNI_W;
   localparam int THR_PROD_W = UNI_W + THR_BITS;

   localparam int REQ_DATA_RAW = 4 * BOX_BITS + CLASS_BITS;
   localparam int REQ_DATA_W   = ((REQ_DATA_RAW + 7) / 8) * 8;
   localparam int REQ_USER_W   = 1;
   localparam int RSP_DATA_RAW = ID_BITS + LIVE_OUT_W + 2 * TOTAL_BITS;
   localparam int RSP_DATA_W   = ((RSP_DATA_RAW + 7) / 8) * 8;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LOST = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IOU_THR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ID = 2'd2;

   localparam logic [MISS_BITS-1:0] MAX_LOST_RST = 8'd30;
   localparam logic [THR_BITS-1:0]  IOU_THR_RST  = 9'd77;
   localparam logic [ID_BITS-1:0]   FIRST_ID_RST = 16'd0;
   localparam logic [MISS_BITS-1:0] MISS_SAT     = 8'hFF;

   localparam logic [STATUS_W-1:0] ST_MATCH = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_DROP  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_AGED  = 2'd3;

   typedef struct packed {
      logic                  live;
      logic                  seen;
      logic                  fresh;
      logic [ID_BITS-1:0]    id;
      logic [CLASS_BITS-1:0] cls;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
      logic [MISS_BITS-1:0]  misses;
   } slot_type;

   typedef struct packed {
      logic [CLASS_BITS-1:0] cls;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] w;
      logic [COORD_BITS-1:0] h;
   } det_type;

   typedef struct packed {
      logic               valid;
      logic [ID_BITS-1:0] id;
      logic [IDX_W-1:0]   step;
      logic [AREA_W-1:0]  inter;
      logic [UNI_W-1:0]   uni;
   } cand_type;

endpackage
`default_nettype wire

[hdl/iouta_cell.sv]
// iouta_cell: one track slot of the rotating slot ring
// depends on iouta_pkg
`timescale 1ns / 1ps
`default_nettype none
module iouta_cell (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 shift,
   input  iouta_pkg::slot_type slot_in,
   output iouta_pkg::slot_type slot_out
);
   import iouta_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.live  <= 1'b0;
         slot_ff.seen  <= 1'b0;
         slot_ff.fresh <= 1'b0;
      end else if (shift) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule
`default_nettype wire

[hdl/iouta_score.sv]
// iouta_score: three-stage eligibility, intersection and union pipeline at the ring head
// depends on iouta_pkg
`timescale 1ns / 1ps
`default_nettype none
module iouta_score (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 valid_in,
   input  wire  [iouta_pkg::IDX_W-1:0]         step_in,
   input  iouta_pkg::slot_type                 slot_in,
   input  iouta_pkg::det_type                  det,
   input  wire  [iouta_pkg::AREA_W-1:0]        det_area,
   input  wire  [iouta_pkg::MISS_BITS-1:0]     max_lost,
   output iouta_pkg::cand_type                 cand
);
   import iouta_pkg::*;

   logic [COORD_BITS:0]   tx_end, ty_end, dx_end, dy_end;
   logic [COORD_BITS:0]   x_lo, x_hi, y_lo, y_hi;
   logic [COORD_BITS-1:0] ox_in, oy_in;
   logic                  elig_in;

   logic                  a_valid_ff, a_elig_ff;
   logic [COORD_BITS-1:0] a_ox_ff, a_oy_ff;
   logic [AREA_W-1:0]     a_area_ff;
   logic [ID_BITS-1:0]    a_id_ff;
   logic [IDX_W-1:0]      a_step_ff;

   logic                  b_valid_ff;
   logic [AREA_W-1:0]     b_inter_ff;
   logic [UNI_W-1:0]      b_sum_ff;
   logic [ID_BITS-1:0]    b_id_ff;
   logic [IDX_W-1:0]      b_step_ff;

   logic                  c_valid_ff;
   logic [AREA_W-1:0]     c_inter_ff;
   logic [UNI_W-1:0]      c_uni_ff;
   logic [ID_BITS-1:0]    c_id_ff;
   logic [IDX_W-1:0]      c_step_ff;

   always_comb begin
      tx_end = {1'b0, slot_in.x} + {1'b0, slot_in.w};
      ty_end = {1'b0, slot_in.y} + {1'b0, slot_in.h};
      dx_end = {1'b0, det.x} + {1'b0, det.w};
      dy_end = {1'b0, det.y} + {1'b0, det.h};
      x_lo   = (slot_in.x > det.x) ? {1'b0, slot_in.x} : {1'b0, det.x};
      y_lo   = (slot_in.y > det.y) ? {1'b0, slot_in.y} : {1'b0, det.y};
      x_hi   = (tx_end < dx_end) ? tx_end : dx_end;
      y_hi   = (ty_end < dy_end) ? ty_end : dy_end;
      ox_in  = (x_hi > x_lo) ? COORD_BITS'(x_hi - x_lo) : '0;
      oy_in  = (y_hi > y_lo) ? COORD_BITS'(y_hi - y_lo) : '0;
      elig_in = slot_in.live && !slot_in.fresh && (slot_in.cls == det.cls) &&
                (slot_in.misses <= (max_lost >> 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= valid_in && elig_in;
         b_valid_ff <= a_valid_ff && a_elig_ff;
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_elig_ff  <= elig_in;
      a_ox_ff    <= ox_in;
      a_oy_ff    <= oy_in;
      a_area_ff  <= slot_in.w * slot_in.h;
      a_id_ff    <= slot_in.id;
      a_step_ff  <= step_in;
      b_inter_ff <= a_ox_ff * a_oy_ff;
      b_sum_ff   <= {1'b0, a_area_ff} + {1'b0, det_area};
      b_id_ff    <= a_id_ff;
      b_step_ff  <= a_step_ff;
      c_inter_ff <= b_inter_ff;
      c_uni_ff   <= b_sum_ff - {1'b0, b_inter_ff};
      c_id_ff    <= b_id_ff;
      c_step_ff  <= b_step_ff;
   end

   always_comb begin
      cand.valid = c_valid_ff && (c_inter_ff != '0) && (c_uni_ff != '0);
      cand.id    = c_id_ff;
      cand.step  = c_step_ff;
      cand.inter = c_inter_ff;
      cand.uni   = c_uni_ff;
   end

endmodule
`default_nettype wire

[hdl/iou_track_association.sv]
// iou_track_association: top level, slot ring, head control and result register
// depends on iouta_pkg, iouta_cell, iouta_score
//
// The track table is a ring of TRACK_SLOTS cells that rotates one slot per cycle past a
// single head during the scoring, write-back and aging rotations. A detection takes one full
// rotation to score every slot; the scoring pipeline then drains and the threshold is
// checked. When a slot is matched or opened, a second rotation writes it back. A frame
// start ages every slot in one rotation. One request is in work at a time; a finished
// result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none
module iou_track_association (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // box_x, box_y, box_w, box_h, class_label
   input  wire  [iouta_pkg::REQ_DATA_W-1:0]    req_tdata,
   // op
   input  wire  [iouta_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // track_number, live_tracks, tracks_opened, tracks_retired
   output logic [iouta_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [iouta_pkg::STATUS_W-1:0]      rsp_tuser,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [iouta_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [iouta_pkg::CSR_DATA_W-1:0]    csr_data
);
   import iouta_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_DECIDE = 6'b000100,
      S_APPLY  = 6'b001000,
      S_AGE    = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff;

   logic [MISS_BITS-1:0]  max_lost_ff;
   logic [THR_BITS-1:0]   thr_ff;
   logic [ID_BITS-1:0]    next_id_ff;
   logic [TOTAL_BITS-1:0] opened_ff, retired_ff;
   logic [LIVE_W-1:0]     live_cnt_ff;

   det_type               det_ff;
   logic [AREA_W-1:0]     det_area_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic                  best_found_ff;
   logic [AREA_W-1:0]     best_i_ff;
   logic [UNI_W-1:0]      best_u_ff;
   logic [ID_BITS-1:0]    best_id_ff;
   logic [IDX_W-1:0]      best_step_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_step_ff;

   logic                  act_open_ff;
   logic [IDX_W-1:0]      tgt_step_ff;
   logic [ID_BITS-1:0]    number_ff;
   logic [STATUS_W-1:0]   status_ff;

   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [STATUS_W-1:0]   rsp_user_ff;
   logic                  rsp_valid_ff;

   slot_type              chain_q [TRACK_SLOTS];
   slot_type              head_in;
   logic                  shift;
   logic [IDX_W-1:0]      step;
   cand_type              cand;
   det_type               req_det;

   logic [PROD_W-1:0]     prod_cand, prod_best;
   logic                  take_cand;
   logic [THR_PROD_W-1:0] thr_lhs, thr_rhs;
   logic                  match;
   logic [MISS_BITS-1:0]  miss_inc;
   logic                  retire_now;
   logic                  req_acc, rsp_load;

   assign step = cnt_ff[IDX_W-1:0];
   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      req_det.x   = req_tdata[COORD_BITS-1:0];
      req_det.y   = req_tdata[BOX_BITS +: COORD_BITS];
      req_det.w   = req_tdata[2*BOX_BITS +: COORD_BITS];
      req_det.h   = req_tdata[3*BOX_BITS +: COORD_BITS];
      req_det.cls = req_tdata[4*BOX_BITS +: CLASS_BITS];
   end

   always_comb begin
      unique case (state_ff)
         S_SCAN:           shift = (cnt_ff < CNT_W'(TRACK_SLOTS));
         S_APPLY, S_AGE:   shift = 1'b1;
         default:          shift = 1'b0;
      endcase
   end

   // ring of slots, head record re-enters at the tail
   for (genvar i = 0; i < TRACK_SLOTS; i++) begin : g_ring
      if (i == TRACK_SLOTS - 1) begin : g_tail
         iouta_cell u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .slot_in(head_in), .slot_out(chain_q[i])
         );
      end else begin : g_mid
         iouta_cell u_cell (
            .clock(clock), .reset(reset), .shift(shift),
            .slot_in(chain_q[i+1]), .slot_out(chain_q[i])
         );
      end
   end

   iouta_score u_score (
      .clock(clock),
      .reset(reset),
      .valid_in((state_ff == S_SCAN) && (cnt_ff < CNT_W'(TRACK_SLOTS))),
      .step_in(step),
      .slot_in(chain_q[0]),
      .det(det_ff),
      .det_area(det_area_ff),
      .max_lost(max_lost_ff),
      .cand(cand)
   );

   // head modification for write-back and aging passes
   always_comb begin
      head_in    = chain_q[0];
      miss_inc   = chain_q[0].misses + MISS_BITS'(chain_q[0].misses != MISS_SAT);
      retire_now = 1'b0;
      if (state_ff == S_AGE) begin
         if (chain_q[0].live && !chain_q[0].seen) begin
            head_in.misses = miss_inc;
            if (miss_inc > max_lost_ff) begin
               head_in.live = 1'b0;
               retire_now   = 1'b1;
            end
         end
         head_in.seen  = 1'b0;
         head_in.fresh = 1'b0;
      end else if ((state_ff == S_APPLY) && (step == tgt_step_ff)) begin
         head_in.x      = det_ff.x;
         head_in.y      = det_ff.y;
         head_in.w      = det_ff.w;
         head_in.h      = det_ff.h;
         head_in.misses = '0;
         head_in.seen   = 1'b1;
         if (act_open_ff) begin
            head_in.live  = 1'b1;
            head_in.fresh = 1'b1;
            head_in.id    = number_ff;
            head_in.cls   = det_ff.cls;
         end
      end
   end

   // running best: cross-multiplied iou compare, lowest id on ties
   always_comb begin
      prod_cand = cand.inter * best_u_ff;
      prod_best = best_i_ff * cand.uni;
      take_cand = cand.valid && (!best_found_ff || (prod_cand > prod_best) ||
                  ((prod_cand == prod_best) && (cand.id < best_id_ff)));
      thr_lhs   = THR_PROD_W'({best_i_ff, 8'h00});
      thr_rhs   = thr_ff * best_u_ff;
      match     = best_found_ff && (thr_lhs >= thr_rhs);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         max_lost_ff   <= MAX_LOST_RST;
         thr_ff        <= IOU_THR_RST;
         next_id_ff    <= FIRST_ID_RST;
         opened_ff     <= '0;
         retired_ff    <= '0;
         live_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         act_open_ff   <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  det_ff        <= req_det;
                  det_area_ff   <= req_det.w * req_det.h;
                  cnt_ff        <= '0;
                  best_found_ff <= 1'b0;
                  free_found_ff <= 1'b0;
                  act_open_ff   <= 1'b0;
                  number_ff     <= '0;
                  status_ff     <= req_tuser[0] ? ST_AGED : ST_DROP;
                  state_ff      <= req_tuser[0] ? S_AGE : S_SCAN;
               end
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (shift && !chain_q[0].live && !free_found_ff) begin
                  free_found_ff <= 1'b1;
                  free_step_ff  <= step;
               end
               if (take_cand) begin
                  best_found_ff <= 1'b1;
                  best_i_ff     <= cand.inter;
                  best_u_ff     <= cand.uni;
                  best_id_ff    <= cand.id;
                  best_step_ff  <= cand.step;
               end
               if (cnt_ff == CNT_W'(TRACK_SLOTS + SCORE_LAT - 1)) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               cnt_ff <= '0;
               if (match) begin
                  tgt_step_ff  <= best_step_ff;
                  number_ff    <= best_id_ff;
                  status_ff    <= ST_MATCH;
                  state_ff     <= S_APPLY;
               end else if (free_found_ff) begin
                  act_open_ff  <= 1'b1;
                  tgt_step_ff  <= free_step_ff;
                  number_ff    <= next_id_ff;
                  status_ff    <= ST_NEW;
                  next_id_ff   <= next_id_ff + 1'b1;
                  opened_ff    <= opened_ff + 1'b1;
                  live_cnt_ff  <= live_cnt_ff + 1'b1;
                  state_ff     <= S_APPLY;
               end else begin
                  status_ff    <= ST_DROP;
                  state_ff     <= S_DONE;
               end
            end
            S_APPLY: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(TRACK_SLOTS - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_AGE: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (retire_now) begin
                  retired_ff  <= retired_ff + 1'b1;
                  live_cnt_ff <= live_cnt_ff - 1'b1;
               end
               if (cnt_ff == CNT_W'(TRACK_SLOTS - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (rsp_load) begin
                  rsp_user_ff  <= status_ff;
                  rsp_data_ff  <= RSP_DATA_W'({retired_ff, opened_ff,
                                               LIVE_OUT_W'(live_cnt_ff), number_ff});
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MAX_LOST: max_lost_ff <= csr_data[MISS_BITS-1:0];
               CSR_IOU_THR:  thr_ff      <= csr_data[THR_BITS-1:0];
               CSR_FIRST_ID: next_id_ff  <= csr_data[ID_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

[hdl/iouta_checker.sv]
// iouta_checker: port-level assertions for iou_track_association, with its bind
// depends on iouta_pkg and the top level iou_track_association
`timescale 1ns / 1ps
`default_nettype none
module iouta_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_tvalid,
   input wire                                 req_tready,
   input wire [iouta_pkg::REQ_DATA_W-1:0]     req_tdata,
   input wire [iouta_pkg::REQ_USER_W-1:0]     req_tuser,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready,
   input wire [iouta_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input wire [iouta_pkg::STATUS_W-1:0]       rsp_tuser
);
   import iouta_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   a_no_number: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_AGED || rsp_tuser == ST_DROP) |->
      rsp_tdata[ID_BITS-1:0] == '0)
      else $error("track number on aged or dropped request");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_DROP |->
      rsp_tdata[ID_BITS +: LIVE_OUT_W] == LIVE_OUT_W'(TRACK_SLOTS))
      else $error("drop reported with free slots");

endmodule

bind iou_track_association iouta_checker u_iouta_checker (.*);
`default_nettype wire
